FILE: rtl/aabb_xf_pkg.sv
// ----------------------------------------------------------------------------
// aabb_xf_pkg
// Shared widths, types and register codes for the box affine transform unit.
// ----------------------------------------------------------------------------
package aabb_xf_pkg;

   localparam int CoordW  = 24;               // signed Q16.8 centre
   localparam int HalfW   = 23;               // unsigned Q15.8 half extent
   localparam int CoefW   = 16;               // signed Q8.8 coefficient
   localparam int FracW   = 8;                // coefficient fraction bits
   localparam int CornerW = CoordW + 1;       // centre +/- half extent
   localparam int ProdW   = CoefW + CornerW;  // full product
   localparam int TermW   = ProdW - FracW;    // product after floor shift
   localparam int SumW    = TermW + 2;        // three terms plus translation
   localparam int AxisN   = 3;
   localparam int RowW    = 4 * CoefW;
   localparam int CsrIdxW = 2;

   localparam logic [RowW-1:0] RowXReset = RowW'(64'd256);
   localparam logic [RowW-1:0] RowYReset = RowW'(64'd1) << 24;
   localparam logic [RowW-1:0] RowZReset = RowW'(64'd1) << 40;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ROW_X = 2'd0,
      CSR_ROW_Y = 2'd1,
      CSR_ROW_Z = 2'd2
   } csr_index_type;

   typedef logic signed [CornerW-1:0] corner_type;
   typedef logic signed [TermW-1:0]   term_type;
   typedef logic signed [SumW-1:0]    sum_type;
   typedef logic        [RowW-1:0]    row_type;

   typedef struct packed {
      sum_type lo;
      sum_type hi;
   } bound_type;

endpackage

FILE: rtl/aabb_xf_row.sv
// ----------------------------------------------------------------------------
// aabb_xf_row
// One output axis: six products, per-column min/max, then summed bounds.
// ----------------------------------------------------------------------------
module aabb_xf_row (
   input  logic                      clock,
   input  aabb_xf_pkg::row_type      row,
   input  aabb_xf_pkg::corner_type   corner_plus  [aabb_xf_pkg::AxisN],
   input  aabb_xf_pkg::corner_type   corner_minus [aabb_xf_pkg::AxisN],
   output aabb_xf_pkg::bound_type    bound
);
   import aabb_xf_pkg::*;

   term_type  t_plus_ff  [AxisN];
   term_type  t_minus_ff [AxisN];
   term_type  t_lo_ff    [AxisN];
   term_type  t_hi_ff    [AxisN];
   bound_type bound_ff;
   bound_type bound_in;

   // stage 2: products, floored to Q.8
   for (genvar k = 0; k < AxisN; k++) begin : g_col
      logic signed [CoefW-1:0] coef;
      logic signed [ProdW-1:0] prod_plus;
      logic signed [ProdW-1:0] prod_minus;

      assign coef       = row[k*CoefW +: CoefW];
      assign prod_plus  = ProdW'(coef) * ProdW'(corner_plus[k]);
      assign prod_minus = ProdW'(coef) * ProdW'(corner_minus[k]);

      always_ff @(posedge clock) begin
         t_plus_ff[k]  <= prod_plus[ProdW-1:FracW];
         t_minus_ff[k] <= prod_minus[ProdW-1:FracW];
      end

      // stage 3: each column picks its own extreme, the sum is separable
      always_ff @(posedge clock) begin
         if (t_plus_ff[k] < t_minus_ff[k]) begin
            t_lo_ff[k] <= t_plus_ff[k];
            t_hi_ff[k] <= t_minus_ff[k];
         end else begin
            t_lo_ff[k] <= t_minus_ff[k];
            t_hi_ff[k] <= t_plus_ff[k];
         end
      end
   end

   // stage 4: sum with translation
   always_comb begin
      sum_type shift;
      shift       = SumW'($signed(row[3*CoefW +: CoefW]));
      bound_in.lo = SumW'(t_lo_ff[0]) + SumW'(t_lo_ff[1]) + SumW'(t_lo_ff[2]) + shift;
      bound_in.hi = SumW'(t_hi_ff[0]) + SumW'(t_hi_ff[1]) + SumW'(t_hi_ff[2]) + shift;
   end

   always_ff @(posedge clock) begin
      bound_ff <= bound_in;
   end

   assign bound = bound_ff;

endmodule

FILE: rtl/aabb_xf_resolve.sv
// ----------------------------------------------------------------------------
// aabb_xf_resolve
// Final stage: halve sum and span of the bounds, saturate, drive the beat.
// ----------------------------------------------------------------------------
module aabb_xf_resolve (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid,
   input  aabb_xf_pkg::bound_type            bound      [aabb_xf_pkg::AxisN],
   output logic                              out_valid,
   output logic signed [aabb_xf_pkg::CoordW-1:0] out_center [aabb_xf_pkg::AxisN],
   output logic        [aabb_xf_pkg::HalfW-1:0]  out_half   [aabb_xf_pkg::AxisN]
);
   import aabb_xf_pkg::*;

   localparam sum_type CtrMax  = SumW'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
   localparam sum_type CtrMin  = -SumW'(64'sd1 <<< (CoordW - 1));
   localparam sum_type HalfMax = SumW'((64'sd1 <<< HalfW) - 64'sd1);

   logic                     valid_ff;
   logic signed [CoordW-1:0] center_ff [AxisN];
   logic        [HalfW-1:0]  half_ff   [AxisN];

   for (genvar a = 0; a < AxisN; a++) begin : g_axis
      logic signed [SumW:0] total;
      logic signed [SumW:0] span;
      sum_type              ctr;
      sum_type              hlf;
      logic signed [CoordW-1:0] center_in;
      logic        [HalfW-1:0]  half_in;

      assign total = (SumW+1)'(bound[a].lo) + (SumW+1)'(bound[a].hi);
      assign span  = (SumW+1)'(bound[a].hi) - (SumW+1)'(bound[a].lo);
      assign ctr   = total[SumW:1];
      assign hlf   = span[SumW:1];

      always_comb begin
         if (ctr > CtrMax) begin
            center_in = CtrMax[CoordW-1:0];
         end else if (ctr < CtrMin) begin
            center_in = CtrMin[CoordW-1:0];
         end else begin
            center_in = ctr[CoordW-1:0];
         end
         if (hlf < 0) begin
            half_in = '0;
         end else if (hlf > HalfMax) begin
            half_in = HalfMax[HalfW-1:0];
         end else begin
            half_in = hlf[HalfW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         center_ff[a] <= center_in;
         half_ff[a]   <= half_in;
      end

      assign out_center[a] = center_ff[a];
      assign out_half[a]   = half_ff[a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid;
      end
   end

   assign out_valid = valid_ff;

endmodule

FILE: rtl/aabb_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// Maps an axis-aligned box through a 3x4 affine matrix (eight-corner bound).
//
//   channel  direction  handshake              payload
//   req      in         start & !busy          req_center_*, req_half_*
//   rsp      out        rsp_valid (one cycle)  rsp_new_center_*, rsp_new_half_*
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One box accepted every cycle outside reset; a result beat leaves through
// the five register stages (corners, products, per-column min/max, bound
// sums, halving and saturation).
// busy is high only during reset; reset clears the valid chain and loads
// the identity matrix. The receiver cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module aabb_affine_transform_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [aabb_xf_pkg::CoordW-1:0]    req_center_x,
   input  logic signed [aabb_xf_pkg::CoordW-1:0]    req_center_y,
   input  logic signed [aabb_xf_pkg::CoordW-1:0]    req_center_z,
   input  logic        [aabb_xf_pkg::HalfW-1:0]     req_half_x,
   input  logic        [aabb_xf_pkg::HalfW-1:0]     req_half_y,
   input  logic        [aabb_xf_pkg::HalfW-1:0]     req_half_z,
   output logic                                     rsp_valid,
   output logic signed [aabb_xf_pkg::CoordW-1:0]    rsp_new_center_x,
   output logic signed [aabb_xf_pkg::CoordW-1:0]    rsp_new_center_y,
   output logic signed [aabb_xf_pkg::CoordW-1:0]    rsp_new_center_z,
   output logic        [aabb_xf_pkg::HalfW-1:0]     rsp_new_half_x,
   output logic        [aabb_xf_pkg::HalfW-1:0]     rsp_new_half_y,
   output logic        [aabb_xf_pkg::HalfW-1:0]     rsp_new_half_z,
   input  logic                                     csr_we,
   input  logic        [aabb_xf_pkg::CsrIdxW-1:0]   csr_index,
   input  logic        [aabb_xf_pkg::RowW-1:0]      csr_wdata
);
   import aabb_xf_pkg::*;

   logic        accept;
   row_type     row_ff [AxisN];
   corner_type  plus_ff  [AxisN];
   corner_type  minus_ff [AxisN];
   corner_type  plus_in  [AxisN];
   corner_type  minus_in [AxisN];
   logic        [4:1] valid_ff;
   logic        [4:1] valid_in;
   bound_type   bound [AxisN];
   logic signed [CoordW-1:0] center_in [AxisN];
   logic        [HalfW-1:0]  half_in   [AxisN];
   logic signed [CoordW-1:0] new_center [AxisN];
   logic        [HalfW-1:0]  new_half   [AxisN];

   assign busy   = reset;
   assign accept = start & ~busy;

   // matrix rows
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[CSR_ROW_X] <= RowXReset;
         row_ff[CSR_ROW_Y] <= RowYReset;
         row_ff[CSR_ROW_Z] <= RowZReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_X: row_ff[CSR_ROW_X] <= csr_wdata;
            CSR_ROW_Y: row_ff[CSR_ROW_Y] <= csr_wdata;
            CSR_ROW_Z: row_ff[CSR_ROW_Z] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: corner coordinates
   assign center_in[0] = req_center_x;
   assign center_in[1] = req_center_y;
   assign center_in[2] = req_center_z;
   assign half_in[0]   = req_half_x;
   assign half_in[1]   = req_half_y;
   assign half_in[2]   = req_half_z;

   for (genvar k = 0; k < AxisN; k++) begin : g_corner
      assign plus_in[k]  = CornerW'(center_in[k]) + $signed({2'b00, half_in[k]});
      assign minus_in[k] = CornerW'(center_in[k]) - $signed({2'b00, half_in[k]});

      always_ff @(posedge clock) begin
         plus_ff[k]  <= plus_in[k];
         minus_ff[k] <= minus_in[k];
      end
   end

   assign valid_in = {valid_ff[3:1], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   for (genvar a = 0; a < AxisN; a++) begin : g_row
      aabb_xf_row u_row (
         .clock        (clock),
         .row          (row_ff[a]),
         .corner_plus  (plus_ff),
         .corner_minus (minus_ff),
         .bound        (bound[a])
      );
   end

   aabb_xf_resolve u_resolve (
      .clock      (clock),
      .reset      (reset),
      .valid      (valid_ff[4]),
      .bound      (bound),
      .out_valid  (rsp_valid),
      .out_center (new_center),
      .out_half   (new_half)
   );

   assign rsp_new_center_x = new_center[0];
   assign rsp_new_center_y = new_center[1];
   assign rsp_new_center_z = new_center[2];
   assign rsp_new_half_x   = new_half[0];
   assign rsp_new_half_y   = new_half[1];
   assign rsp_new_half_z   = new_half[2];

`ifndef NO_ASSERTIONS
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("accepted box produced no result beat");

   a_latency_bwd : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result beat without a matching accepted box");

   a_bound_order : assert property (@(posedge clock) disable iff (reset)
      valid_ff[4] |-> (bound[0].lo <= bound[0].hi) && (bound[1].lo <= bound[1].hi)
                      && (bound[2].lo <= bound[2].hi))
      else $error("bound minimum above maximum");

   a_reset_quiet : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");
`endif

endmodule

FILE: tb/tb_aabb_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform_unit
// Self-checking bench for the box affine transform unit. A directed table
// covers identity pass-through, field extremes, saturation, product
// truncation, floor halving and a write to the spare register index. It is
// followed by random boxes under ten matrix settings. Accepted boxes with no
// expected result in the table run through a local eight-corner predictor,
// and each result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_aabb_affine_transform_unit;
   import aabb_xf_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int DrainCycles   = 10;
   localparam int PhaseN        = 10;
   localparam int PhaseItems    = 185;
   localparam int DirN          = 21;

   localparam logic [CsrIdxW-1:0]       CsrIdxSpare = 2'd3;
   localparam logic signed [CoordW-1:0] CtrMin  = {1'b1, {(CoordW-1){1'b0}}};
   localparam logic signed [CoordW-1:0] CtrMax  = {1'b0, {(CoordW-1){1'b1}}};
   localparam logic [HalfW-1:0]         HalfMax = '1;

   typedef struct packed {
      logic signed [CoordW-1:0] cx;
      logic signed [CoordW-1:0] cy;
      logic signed [CoordW-1:0] cz;
      logic [HalfW-1:0]         hx;
      logic [HalfW-1:0]         hy;
      logic [HalfW-1:0]         hz;
   } box_type;

   typedef enum logic {STEP_BOX, STEP_CSR} step_kind_type;

   typedef enum int {
      MX_IDENTITY, MX_ALL_MAX, MX_ALL_MIN, MX_ALL_NEG_LSB, MX_ZERO, MX_MODERATE, MX_RANDOM
   } matrix_kind_type;

   typedef struct {
      step_kind_type        kind;
      logic [CsrIdxW-1:0]   idx;
      row_type              data;
      box_type              box;
      bit                   known;
      box_type              want;
   } step_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [CoordW-1:0] req_center_x = '0;
   logic signed [CoordW-1:0] req_center_y = '0;
   logic signed [CoordW-1:0] req_center_z = '0;
   logic [HalfW-1:0]     req_half_x = '0;
   logic [HalfW-1:0]     req_half_y = '0;
   logic [HalfW-1:0]     req_half_z = '0;
   logic                 rsp_valid;
   logic signed [CoordW-1:0] rsp_new_center_x;
   logic signed [CoordW-1:0] rsp_new_center_y;
   logic signed [CoordW-1:0] rsp_new_center_z;
   logic [HalfW-1:0]     rsp_new_half_x;
   logic [HalfW-1:0]     rsp_new_half_y;
   logic [HalfW-1:0]     rsp_new_half_z;
   logic                 csr_we = 1'b0;
   logic [CsrIdxW-1:0]   csr_index = '0;
   row_type              csr_wdata = '0;

   row_type xf_rows [AxisN] = '{RowXReset, RowYReset, RowZReset};
   box_type expected_boxes [$];
   int      mismatch_count = 0;
   int      quiet_cycles = 0;

   matrix_kind_type phase_kind [PhaseN] = '{
      MX_MODERATE, MX_RANDOM, MX_ALL_MAX, MX_MODERATE, MX_ALL_MIN,
      MX_ALL_NEG_LSB, MX_ZERO, MX_IDENTITY, MX_MODERATE, MX_RANDOM
   };

   // identity rows expect the input back unchanged
   step_type directed_steps [DirN] = '{
      '{STEP_BOX, CSR_ROW_X, '0, '{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0, 0}},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMax, CtrMax, CtrMax, HalfMax, HalfMax, HalfMax},
        1'b1, '{CtrMax, CtrMax, CtrMax, HalfMax, HalfMax, HalfMax}},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMin, CtrMin, CtrMin, 0, 0, 0},
        1'b1, '{CtrMin, CtrMin, CtrMin, 0, 0, 0}},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMin, CtrMin, CtrMin, HalfMax, HalfMax, HalfMax},
        1'b1, '{CtrMin, CtrMin, CtrMin, HalfMax, HalfMax, HalfMax}},
      '{STEP_BOX, CSR_ROW_X, '0, '{-1, 1, -256, 1, 2, 3}, 1'b1, '{-1, 1, -256, 1, 2, 3}},
      '{STEP_BOX, CSR_ROW_X, '0,
        '{24'h555555, 24'hAAAAAA, 24'h0F0F0F, 23'h2AAAAA, 23'h555555, 23'h70F0F0}, 1'b1,
        '{24'h555555, 24'hAAAAAA, 24'h0F0F0F, 23'h2AAAAA, 23'h555555, 23'h70F0F0}},
      '{STEP_CSR, CsrIdxSpare, '1, '0, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{123456, -654321, 77, 5, 0, 1000},
        1'b1, '{123456, -654321, 77, 5, 0, 1000}},
      '{STEP_CSR, CSR_ROW_X, {4{16'h7FFF}}, '0, 1'b0, '0},
      '{STEP_CSR, CSR_ROW_Y, {4{16'h8000}}, '0, 1'b0, '0},
      '{STEP_CSR, CSR_ROW_Z, {4{16'hFFFF}}, '0, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMax, CtrMax, CtrMax, HalfMax, HalfMax, HalfMax},
        1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMin, CtrMin, CtrMin, HalfMax, HalfMax, HalfMax},
        1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{1, -1, 3, 1, 1, 1}, 1'b0, '0},
      '{STEP_CSR, CSR_ROW_X, {16'h0101, 16'h0000, 16'h0000, 16'h0080}, '0, 1'b0, '0},
      '{STEP_CSR, CSR_ROW_Y, {16'hFF00, 16'h0000, 16'h0000, 16'hFF80}, '0, 1'b0, '0},
      '{STEP_CSR, CSR_ROW_Z, {16'h0000, 16'h0180, 16'h0000, 16'h0000}, '0, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{3, -5, 7, 1, 2, 3}, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{CtrMin, CtrMax, -1, HalfMax, 0, 1}, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{-3, 9, -7, 0, 0, 0}, 1'b0, '0},
      '{STEP_BOX, CSR_ROW_X, '0, '{0, 0, 0, 0, 0, 0}, 1'b0, '0}
   };

   aabb_affine_transform_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_half_x       (req_half_x),
      .req_half_y       (req_half_y),
      .req_half_z       (req_half_z),
      .rsp_valid        (rsp_valid),
      .rsp_new_center_x (rsp_new_center_x),
      .rsp_new_center_y (rsp_new_center_y),
      .rsp_new_center_z (rsp_new_center_z),
      .rsp_new_half_x   (rsp_new_half_x),
      .rsp_new_half_y   (rsp_new_half_y),
      .rsp_new_half_z   (rsp_new_half_z),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint coef_of(int axis, int col);
      logic signed [CoefW-1:0] c;
      c = xf_rows[axis][CoefW*col +: CoefW];
      return c;
   endfunction

   // eight corners through the matrix, per-axis bound, then floor halving
   function automatic box_type transform_box(box_type b);
      longint  ctr [3];
      longint  half [3];
      longint  lo [3];
      longint  hi [3];
      longint  p [3];
      longint  acc;
      longint  cc;
      longint  hh;
      box_type r;
      ctr[0] = $signed(b.cx);
      ctr[1] = $signed(b.cy);
      ctr[2] = $signed(b.cz);
      half[0] = b.hx;
      half[1] = b.hy;
      half[2] = b.hz;
      for (int i = 0; i < 8; i++) begin
         p[0] = i[2] ? ctr[0] - half[0] : ctr[0] + half[0];
         p[1] = i[1] ? ctr[1] - half[1] : ctr[1] + half[1];
         p[2] = i[0] ? ctr[2] - half[2] : ctr[2] + half[2];
         for (int a = 0; a < AxisN; a++) begin
            acc = coef_of(a, 3);
            for (int k = 0; k < 3; k++) begin
               acc += (coef_of(a, k) * p[k]) >>> FracW;
            end
            if (i == 0 || acc < lo[a]) lo[a] = acc;
            if (i == 0 || acc > hi[a]) hi[a] = acc;
         end
      end
      for (int a = 0; a < AxisN; a++) begin
         cc = (lo[a] + hi[a]) >>> 1;
         hh = (hi[a] - lo[a]) >>> 1;
         if (cc < longint'(CtrMin)) cc = CtrMin;
         if (cc > longint'(CtrMax)) cc = CtrMax;
         if (hh < 0) hh = 0;
         if (hh > longint'(HalfMax)) hh = HalfMax;
         case (a)
            0: begin
               r.cx = cc[CoordW-1:0];
               r.hx = hh[HalfW-1:0];
            end
            1: begin
               r.cy = cc[CoordW-1:0];
               r.hy = hh[HalfW-1:0];
            end
            default: begin
               r.cz = cc[CoordW-1:0];
               r.hz = hh[HalfW-1:0];
            end
         endcase
      end
      return r;
   endfunction

   function automatic row_type make_row(matrix_kind_type kind, int axis);
      row_type r;
      case (kind)
         MX_IDENTITY: r = (axis == 0) ? RowXReset : (axis == 1) ? RowYReset : RowZReset;
         MX_ALL_MAX: r = {4{16'h7FFF}};
         MX_ALL_MIN: r = {4{16'h8000}};
         MX_ALL_NEG_LSB: r = {4{16'hFFFF}};
         MX_ZERO: r = '0;
         MX_MODERATE: begin
            for (int k = 0; k < 3; k++) begin
               r[CoefW*k +: CoefW] = CoefW'(int'($urandom_range(0, 1024)) - 512);
            end
            r[RowW-1 -: CoefW] = CoefW'($urandom());
         end
         default: r = {$urandom(), $urandom()};
      endcase
      return r;
   endfunction

   function automatic logic signed [CoordW-1:0] corner_ctr();
      case ($urandom_range(0, 3))
         0: return CtrMin;
         1: return CtrMax;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [HalfW-1:0] corner_half();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return HalfMax;
         2: return HalfW'(1);
         default: return HalfMax - 1'b1;
      endcase
   endfunction

   function automatic box_type random_box();
      box_type     b;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      b.cx = CoordW'($urandom());
      b.cy = CoordW'($urandom());
      b.cz = CoordW'($urandom());
      b.hx = HalfW'($urandom());
      b.hy = HalfW'($urandom());
      b.hz = HalfW'($urandom());
      if (mode >= 5 && mode <= 7) begin
         b.cx = CoordW'(int'($urandom_range(0, 8192)) - 4096);
         b.cy = CoordW'(int'($urandom_range(0, 8192)) - 4096);
         b.cz = CoordW'(int'($urandom_range(0, 8192)) - 4096);
         b.hx = HalfW'($urandom_range(0, 4096));
         b.hy = HalfW'($urandom_range(0, 4096));
         b.hz = HalfW'($urandom_range(0, 4096));
      end else if (mode == 8) begin
         b.cx = corner_ctr();
         b.cy = corner_ctr();
         b.cz = corner_ctr();
         b.hx = corner_half();
         b.hy = corner_half();
         b.hz = corner_half();
      end
      return b;
   endfunction

   function automatic int pick_gap(bit quiet);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_box(box_type b, bit known, box_type want);
      req_center_x <= b.cx;
      req_center_y <= b.cy;
      req_center_z <= b.cz;
      req_half_x   <= b.hx;
      req_half_y   <= b.hy;
      req_half_z   <= b.hz;
      start        <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      expected_boxes.push_back(known ? want : transform_box(b));
   endtask

   task automatic pause_sender(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // every box gives one beat, so an empty queue means the pipe is empty
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_boxes.size() != 0);
   endtask

   // leaves csr_we high; the caller lowers it after its last write
   task automatic write_reg(logic [CsrIdxW-1:0] idx, row_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (csr_index_type'(idx))
         CSR_ROW_X: xf_rows[0] = data;
         CSR_ROW_Y: xf_rows[1] = data;
         CSR_ROW_Z: xf_rows[2] = data;
         default: ;
      endcase
   endtask

   task automatic check_field(string name, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      box_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_boxes.size() == 0) begin
            $display("%0t: unexpected result beat, expected none got %h %h %h %h %h %h",
                     $time, rsp_new_center_x, rsp_new_center_y, rsp_new_center_z,
                     rsp_new_half_x, rsp_new_half_y, rsp_new_half_z);
            mismatch_count++;
         end else begin
            want = expected_boxes.pop_front();
            check_field("centre x", want.cx, rsp_new_center_x);
            check_field("centre y", want.cy, rsp_new_center_y);
            check_field("centre z", want.cz, rsp_new_center_z);
            check_field("half x", CoordW'(want.hx), CoordW'(rsp_new_half_x));
            check_field("half y", CoordW'(want.hy), CoordW'(rsp_new_half_y));
            check_field("half z", CoordW'(want.hz), CoordW'(rsp_new_half_z));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("** aabb_affine_transform_unit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int gap;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DirN; i++) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            if (i == 0 || directed_steps[i-1].kind != STEP_CSR) wait_drained();
            write_reg(directed_steps[i].idx, directed_steps[i].data);
            if (i == DirN - 1 || directed_steps[i+1].kind != STEP_CSR) csr_we <= 1'b0;
         end else begin
            send_box(directed_steps[i].box, directed_steps[i].known, directed_steps[i].want);
         end
      end

      for (int ph = 0; ph < PhaseN; ph++) begin
         wait_drained();
         write_reg(CsrIdxSpare, {$urandom(), $urandom()});
         write_reg(CSR_ROW_X, make_row(phase_kind[ph], 0));
         write_reg(CSR_ROW_Y, make_row(phase_kind[ph], 1));
         write_reg(CSR_ROW_Z, make_row(phase_kind[ph], 2));
         csr_we <= 1'b0;
         for (int n = 0; n < PhaseItems; n++) begin
            send_box(random_box(), 1'b0, '0);
            gap = pick_gap(ph == 3);
            if (gap > 0) pause_sender(gap);
            if ($urandom_range(0, 199) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_boxes.size() == 0) begin
         $display("** aabb_affine_transform_unit: PASSED **");
      end else begin
         $display("** aabb_affine_transform_unit: FAILED **");
      end
      $finish;
   end

endmodule
